// ----- rtl/bfa_pkg.sv -----
`default_nettype none

package bfa_pkg;

  // Table geometry.
  localparam int NUM_BLOCKS = 8;
  localparam int SIZE_BITS  = 16;

  // Index bits for the table and counter bits that can hold the block count itself.
  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  // Register and field widths.
  localparam int COUNT_W     = 4;
  localparam int COUNT_RESET = 8;

  // Item modes.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // One input beat.
  typedef struct packed {
    logic        mode;
    logic [2:0]  block_index;
    logic [15:0] block_size;
    logic [15:0] request_size;
  } bfa_in_t;

  // One result beat.
  typedef struct packed {
    logic       granted;
    logic [2:0] chosen_block;
  } bfa_out_t;

endpackage

`default_nettype wire

// ----- rtl/bfa_size_ram.sv -----
`default_nettype none

// Simple dual-port RAM with one write port and one registered read port.
module bfa_size_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW    = 3
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/best_fit_block_allocator_core.sv -----
`default_nettype none

// Loads are taken one per cycle, back to back, and give no result. A request scans the
// N = block_count blocks (saturated to the table size) one per cycle, then the TAIL state
// finishes the last compare and the FINISH state issues the result (with N = 0 the scan and
// TAIL are skipped). FINISH waits while a stalled earlier result holds the result register,
// and no new beat is taken until the request is through. Synchronous active-low reset frees
// every block and sets block_count to 8; sizes are undefined until loaded.
module best_fit_block_allocator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire bfa_pkg::bfa_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output bfa_pkg::bfa_out_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [bfa_pkg::COUNT_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FINISH
  } state_t;

  state_t                              state_r, state_nxt;
  logic [bfa_pkg::COUNT_W-1:0]         count_r;
  logic [bfa_pkg::NUM_BLOCKS-1:0]      busy_r, busy_nxt;
  logic [bfa_pkg::CNT_W-1:0]           limit_r, limit_nxt;
  logic [bfa_pkg::CNT_W-1:0]           issue_r, issue_nxt;
  logic                                cmp_vld_r, cmp_vld_nxt;
  logic [bfa_pkg::IDX_W-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic                                found_r, found_nxt;
  logic [bfa_pkg::IDX_W-1:0]           best_idx_r, best_idx_nxt;
  logic [bfa_pkg::SIZE_BITS-1:0]       best_size_r, best_size_nxt;
  logic [bfa_pkg::SIZE_BITS-1:0]       req_r;
  logic                                out_valid_r, out_valid_nxt;
  bfa_pkg::bfa_out_t                   out_data_r;

  logic                                in_accept;
  logic                                emit;
  logic                                ram_we;
  logic [bfa_pkg::IDX_W-1:0]           ram_waddr;
  logic [bfa_pkg::SIZE_BITS-1:0]       ram_wdata;
  logic [bfa_pkg::SIZE_BITS-1:0]       ram_rdata;
  logic [bfa_pkg::CNT_W-1:0]           limit_cfg;
  logic                                cand;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The result register is free when empty or when its beat leaves this cycle.
  assign emit = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // Block count saturated to the table size.
  assign limit_cfg = (32'(count_r) > 32'(bfa_pkg::NUM_BLOCKS)) ?
                     bfa_pkg::CNT_W'(bfa_pkg::NUM_BLOCKS) : bfa_pkg::CNT_W'(count_r);

  // Loads write the size RAM directly; indexes past the table are dropped.
  assign ram_we    = in_accept && (in_data.mode == bfa_pkg::MODE_LOAD) &&
                     (32'(in_data.block_index) < 32'(bfa_pkg::NUM_BLOCKS));
  assign ram_waddr = bfa_pkg::IDX_W'(in_data.block_index);
  assign ram_wdata = bfa_pkg::SIZE_BITS'(in_data.block_size);

  bfa_size_ram #(
    .DEPTH (bfa_pkg::NUM_BLOCKS),
    .WIDTH (bfa_pkg::SIZE_BITS),
    .AW    (bfa_pkg::IDX_W)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_r[bfa_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // A block read last cycle is a better fit if free, large enough and strictly smaller.
  assign cand = cmp_vld_r && !busy_r[cmp_idx_r] && (ram_rdata >= req_r) &&
                (!found_r || (ram_rdata < best_size_r));

  // Next-state logic for the sequencer and the running best fit.
  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    limit_nxt     = limit_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = issue_r[bfa_pkg::IDX_W-1:0];
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cand) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = cmp_idx_r;
      best_size_nxt = ram_rdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.mode == bfa_pkg::MODE_LOAD) begin
            if (ram_we) begin
              busy_nxt[ram_waddr] = 1'b0;
            end
          end else begin
            limit_nxt = limit_cfg;
            issue_nxt = '0;
            found_nxt = 1'b0;
            state_nxt = (limit_cfg == '0) ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = 1'b1;
        issue_nxt   = issue_r + 1'b1;
        if (issue_r == limit_r - 1'b1) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            busy_nxt[best_idx_r] = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer state, busy marks, the block count and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= '0;
      count_r     <= bfa_pkg::COUNT_W'(bfa_pkg::COUNT_RESET);
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (emit) begin
        out_data_r.granted      <= found_r;
        out_data_r.chosen_block <= found_r ? 3'(best_idx_r) : 3'd0;
      end
    end
  end

  // Working registers of the scan.
  always_ff @(posedge clk) begin
    limit_r     <= limit_nxt;
    issue_r     <= issue_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    if (in_accept) begin
      req_r <= bfa_pkg::SIZE_BITS'(in_data.request_size);
    end
  end

  // A granted block is marked busy right after its result is issued.
  a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && found_r) |=> busy_r[$past(best_idx_r)])
    else $error("granted block not marked busy");

  // Compares happen only while a scan is running.
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == ST_SCAN || state_r == ST_TAIL))
    else $error("compare outside a scan");

  // The best fit always lies inside the participating blocks.
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && state_r == ST_FINISH) |-> (32'(best_idx_r) < 32'(limit_r)))
    else $error("best fit outside the block count");

  // A refusal carries block zero.
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.granted) |-> (out_data_r.chosen_block == 3'd0))
    else $error("refusal with nonzero block");

endmodule

`default_nettype wire

// ----- bench/best_fit_block_allocator_core_test.sv -----
`timescale 1ns / 100ps

module best_fit_block_allocator_core_test;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 17;
  localparam int PHASE_BEATS   = 100;

  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  bfa_pkg::bfa_in_t            in_data   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  bfa_pkg::bfa_out_t           out_data;
  logic                        cfg_we    = 1'b0;
  logic [bfa_pkg::COUNT_W-1:0] cfg_wdata = '0;

  // Shadow copy of the allocation table and the block count.
  logic [bfa_pkg::SIZE_BITS-1:0] blk_size [bfa_pkg::NUM_BLOCKS];
  logic                          blk_busy [bfa_pkg::NUM_BLOCKS];
  logic [bfa_pkg::COUNT_W-1:0]   blk_count;

  // Grants and refusals still owed by the block, oldest first.
  bfa_pkg::bfa_out_t expected_grants[$];

  int mismatch_count    = 0;
  int cycle_count       = 0;
  int burst_left        = 0;
  bit long_hold_pending = 1'b0;

  best_fit_block_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Loads update the table; requests pick the smallest free block that fits.
  function automatic void allocate_or_load(input bfa_pkg::bfa_in_t beat);
    int                limit;
    int                pick;
    bit                found;
    bfa_pkg::bfa_out_t grant;
    if (beat.mode == bfa_pkg::MODE_LOAD) begin
      if (int'(beat.block_index) < bfa_pkg::NUM_BLOCKS) begin
        blk_size[beat.block_index] = beat.block_size;
        blk_busy[beat.block_index] = 1'b0;
      end
      return;
    end
    limit = (int'(blk_count) > bfa_pkg::NUM_BLOCKS) ? bfa_pkg::NUM_BLOCKS : int'(blk_count);
    found = 1'b0;
    pick  = 0;
    for (int j = 0; j < limit; j++) begin
      if (!blk_busy[j] && blk_size[j] >= beat.request_size &&
          (!found || blk_size[j] < blk_size[pick])) begin
        pick  = j;
        found = 1'b1;
      end
    end
    grant.granted      = found;
    grant.chosen_block = found ? 3'(pick) : '0;
    if (found) blk_busy[pick] = 1'b1;
    expected_grants.push_back(grant);
  endfunction

  // Offer one beat and hold it until accepted. Bursts of random length are
  // separated by random gaps; within a burst valid stays high.
  task automatic send_beat(input bfa_pkg::bfa_in_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    allocate_or_load(beat);
  endtask

  task automatic send_load(input logic [2:0] idx,
                           input logic [bfa_pkg::SIZE_BITS-1:0] size);
    bfa_pkg::bfa_in_t beat;
    beat.mode         = bfa_pkg::MODE_LOAD;
    beat.block_index  = idx;
    beat.block_size   = size;
    beat.request_size = 16'($urandom);
    send_beat(beat);
  endtask

  task automatic send_request(input logic [bfa_pkg::SIZE_BITS-1:0] size);
    bfa_pkg::bfa_in_t beat;
    beat.mode         = bfa_pkg::MODE_REQUEST;
    beat.block_index  = 3'($urandom);
    beat.block_size   = 16'($urandom);
    beat.request_size = size;
    send_beat(beat);
  endtask

  // Random beat; request sizes often track sizes already in the table so
  // that exact fits, near misses and ties all occur.
  task automatic send_random_beat(input int request_pct);
    bfa_pkg::bfa_in_t beat;
    beat.mode         = ($urandom_range(0, 99) < request_pct) ?
                        bfa_pkg::MODE_REQUEST : bfa_pkg::MODE_LOAD;
    beat.block_index  = 3'($urandom);
    beat.request_size = 16'($urandom);
    case ($urandom_range(0, 4))
      0:       beat.block_size = 16'($urandom_range(0, 7) * 4096);
      1:       beat.block_size = $urandom_range(0, 1) ? '1 : '0;
      default: beat.block_size = 16'($urandom);
    endcase
    if (beat.mode == bfa_pkg::MODE_REQUEST) begin
      case ($urandom_range(0, 5)) inside
        0:       beat.request_size = '0;
        1:       beat.request_size = '1;
        [2:3]:   beat.request_size = blk_size[$urandom_range(0, bfa_pkg::NUM_BLOCKS - 1)];
        4:       beat.request_size =
                   blk_size[$urandom_range(0, bfa_pkg::NUM_BLOCKS - 1)] + 1'b1;
        default: ;
      endcase
    end
    send_beat(beat);
  endtask

  // Stop offering beats and wait until the block has nothing left to do.
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_count(input logic [bfa_pkg::COUNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    blk_count  = value;
  endtask

  // Fill the whole table, then check smallest fit, ties, zero size and refusal.
  task automatic test_best_fit_rules();
    logic [bfa_pkg::SIZE_BITS-1:0] sizes [bfa_pkg::NUM_BLOCKS] =
      '{16'h0000, 16'hFFFF, 16'd100, 16'd100, 16'd50, 16'd200, 16'h8000, 16'd1};
    for (int i = 0; i < bfa_pkg::NUM_BLOCKS; i++) send_load(3'(i), sizes[i]);
    send_request(16'h0000);
    send_request(16'hFFFF);
    send_request(16'd100);
    send_request(16'd100);
    send_request(16'hFFFF);
  endtask

  // Zero count refuses everything, one block only, and a count above the
  // table size behaves as the full table.
  task automatic test_block_count_limits();
    settle();
    write_block_count('0);
    send_request(16'h0000);
    settle();
    write_block_count(4'd1);
    send_load(3'd0, 16'd7);
    send_request(16'h0000);
    send_request(16'h0000);
    settle();
    write_block_count('1);
    send_request(16'd1);
    settle();
    write_block_count(4'(bfa_pkg::NUM_BLOCKS));
  endtask

  // Hold the result side for a long stretch while beats keep coming, so the
  // block fills up and stalls its input.
  task automatic test_result_backpressure();
    long_hold_pending = 1'b1;
    repeat (40) send_random_beat(60);
  endtask

  task automatic test_random_traffic();
    logic [bfa_pkg::COUNT_W-1:0] extremes [4] =
      '{4'd0, 4'd1, 4'(bfa_pkg::NUM_BLOCKS), 4'hF};
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if ($urandom_range(0, 3) == 0) write_block_count(extremes[$urandom_range(0, 3)]);
      else write_block_count(bfa_pkg::COUNT_W'($urandom));
      repeat (PHASE_BEATS) send_random_beat($urandom_range(30, 80));
    end
  endtask

  // Receiver stall pattern: stretches of random length, each with its own
  // stall density, and a long hold-off when the test asks for one.
  initial begin : result_stall_pattern
    int stretch;
    int stall_pct;
    forever begin
      stretch = $urandom_range(10, 150);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (stretch) begin
        @(posedge clk);
        if (long_hold_pending) begin
          long_hold_pending = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_grants
    bfa_pkg::bfa_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result: granted %0b block %0d",
                 $time, out_data.granted, out_data.chosen_block);
        mismatch_count++;
      end else begin
        want = expected_grants.pop_front();
        if (out_data.granted !== want.granted) begin
          $display("%0t: granted mismatch: expected %0b actual %0b",
                   $time, want.granted, out_data.granted);
          mismatch_count++;
        end
        if (out_data.chosen_block !== want.chosen_block) begin
          $display("%0t: chosen_block mismatch: expected %0d actual %0d",
                   $time, want.chosen_block, out_data.chosen_block);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d results outstanding",
               $time, expected_grants.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < bfa_pkg::NUM_BLOCKS; i++) blk_busy[i] = 1'b0;
    blk_count = bfa_pkg::COUNT_W'(bfa_pkg::COUNT_RESET);
    @(posedge clk);

    test_best_fit_rules();
    test_block_count_limits();
    test_result_backpressure();
    test_random_traffic();

    settle();
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
